// ----- hdl/tafp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tafp_pkg
// Shared types and constants for the triangle angle block.
// -----------------------------------------------------------------------------
package tafp_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int RAD_W    = 19;
   localparam int DEG_W    = 25;
   localparam int OUT_BITS = 3 * (RAD_W + DEG_W) + 3;
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

   localparam int Q30_W     = 31;
   localparam int SUM_W     = 32;
   localparam int DVD_W     = 33;
   localparam int COS_STEPS = 31;

   localparam logic [SUM_W-1:0] HALF_PI_Q30     = 32'd1686629713;
   localparam logic [SUM_W-1:0] ONE_Q30         = 32'd1073741824;
   localparam logic [29:0]      DEG_PER_RAD_Q24 = 30'd961263669;

   // series terms: x/6 directly, 3x/40 as (3x >> 3)/5, 5x/112 as (5x >> 4)/7,
   // each as a multiply by ceil(2^34 / d), exact for dividends below 2^31
   localparam int          K_RECIP_SHIFT   = 34;
   localparam logic [31:0] K_RECIP_SIXTH   = 32'd2863311531;
   localparam logic [31:0] K_RECIP_FIFTH   = 32'd3435973837;
   localparam logic [31:0] K_RECIP_SEVENTH = 32'd2454267027;

   localparam logic [1:0] K_CUBE    = 2'd0;
   localparam logic [1:0] K_FIFTH   = 2'd1;
   localparam logic [1:0] K_SEVENTH = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_SQRT_DONE,
      OP_DEN,
      OP_CHECK,
      OP_COS_INIT,
      OP_DIV_STEP,
      OP_COS_DONE,
      OP_M2,
      OP_M3,
      OP_M5,
      OP_M7,
      OP_K_INIT,
      OP_K_ACC,
      OP_FIN,
      OP_DEG,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
      logic [1:0] k;
   } cmd_type;

   typedef struct packed {
      logic err;
   } stat_type;

   function automatic logic [31:0] k_recip(input logic [1:0] k);
      logic [31:0] r;
      unique case (k)
         K_CUBE:  r = K_RECIP_SIXTH;
         K_FIFTH: r = K_RECIP_FIFTH;
         default: r = K_RECIP_SEVENTH;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/tafp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tafp_dp
// Datapath: squared sides, digit-by-digit roots, shared shift-subtract divider,
// one shared multiplier, series and output formatting.
// -----------------------------------------------------------------------------
module tafp_dp
   import tafp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire cmd_type                  cmd,
   input  wire logic [6*COORD_WIDTH-1:0] coords,
   output stat_type                      stat,
   output logic [OUT_W-1:0]              result
);

   localparam int CW   = COORD_WIDTH;
   localparam int RW   = CW + 9;
   localparam int VW   = 2 * RW;
   localparam int SQW  = 2 * CW + 1;
   localparam int DW   = 2 * CW + 19;
   localparam int NW   = 2 * CW + 3;
   localparam int MULW = (RW > 32) ? RW : 32;
   localparam int PW   = 2 * MULW;

   logic signed [CW-1:0] pt_ff [6];
   logic signed [CW-1:0] pt_in [6];
   logic [SQW-1:0]   acc_ff, acc_in;
   logic [SQW-1:0]   sa_ff, sa_in, sb_ff, sb_in, sc_ff, sc_in;
   logic [RW-1:0]    la_ff, la_in, lb_ff, lb_in, lc_ff, lc_in;
   logic [VW-1:0]    sv_ff, sv_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [RW+1:0]    srem_ff, srem_in;
   logic [DW-1:0]    den_ff, den_in, mag_ff, mag_in, rem_ff, rem_in;
   logic             neg_ff, neg_in, err_ff, err_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [Q30_W-1:0] c30_ff, c30_in, m2_ff, m2_in, m3_ff, m3_in;
   logic [Q30_W-1:0] m5_ff, m5_in, m7_ff, m7_in;
   logic [SUM_W-1:0] sum_ff, sum_in, r30_ff, r30_in;
   logic [RAD_W-1:0] rad_ff [3];
   logic [RAD_W-1:0] rad_in [3];
   logic [DEG_W-1:0] deg_ff [3];
   logic [DEG_W-1:0] deg_in [3];
   logic [2:0]       errs_ff, errs_in;
   logic [OUT_W-1:0] out_ff, out_in;

   logic signed [CW-1:0] ax, ay, bx, by;
   logic signed [CW:0]   dx, dy;
   logic [CW-1:0]        adx, ady;
   logic [SQW-1:0]       s_opp, s_p, s_q;
   logic [RW-1:0]        l_p, l_q, l_sel;
   logic [SQW-1:0]       s_sel;
   logic [MULW-1:0]      mul_a, mul_b;
   logic [PW-1:0]        prod, prod_rnd, deg_rnd;
   logic [Q30_W-1:0]     q30;
   logic signed [NW-1:0] num;
   logic [NW-1:0]        num_abs;
   logic [DW:0]          div_r2;
   logic                 div_ge;
   logic [RW+3:0]        sq_r2, sq_trial;
   logic                 sq_ge;
   logic [SUM_W-1:0]     rad_rnd;
   logic [RAD_W-1:0]     rad_val;
   logic [DEG_W-1:0]     deg_val;

   always_comb begin
      unique case (cmd.idx)
         2'd0: begin
            ax = pt_ff[0]; ay = pt_ff[1]; bx = pt_ff[2]; by = pt_ff[3];
            s_sel = sa_ff;
         end
         2'd1: begin
            ax = pt_ff[2]; ay = pt_ff[3]; bx = pt_ff[4]; by = pt_ff[5];
            s_sel = sb_ff;
         end
         default: begin
            ax = pt_ff[0]; ay = pt_ff[1]; bx = pt_ff[4]; by = pt_ff[5];
            s_sel = sc_ff;
         end
      endcase
      dx  = (CW+1)'(bx) - (CW+1)'(ax);
      dy  = (CW+1)'(by) - (CW+1)'(ay);
      adx = CW'(dx[CW] ? -dx : dx);
      ady = CW'(dy[CW] ? -dy : dy);
      // angle 0: a opposite; angle 1: b opposite; angle 2: c opposite
      unique case (cmd.idx)
         2'd0: begin
            s_opp = sa_ff; s_p = sb_ff; s_q = sc_ff; l_p = lb_ff; l_q = lc_ff;
         end
         2'd1: begin
            s_opp = sb_ff; s_p = sa_ff; s_q = sc_ff; l_p = la_ff; l_q = lc_ff;
         end
         default: begin
            s_opp = sc_ff; s_p = sa_ff; s_q = sb_ff; l_p = la_ff; l_q = lb_ff;
         end
      endcase
      l_sel = root_ff;
   end

   always_comb begin
      unique case (cmd.op)
         OP_SQX:  begin mul_a = MULW'(adx);    mul_b = MULW'(adx);             end
         OP_SQY:  begin mul_a = MULW'(ady);    mul_b = MULW'(ady);             end
         OP_DEN:  begin mul_a = MULW'(l_p);    mul_b = MULW'(l_q);             end
         OP_M2:   begin mul_a = MULW'(c30_ff); mul_b = MULW'(c30_ff);          end
         OP_M3:   begin mul_a = MULW'(m2_ff);  mul_b = MULW'(c30_ff);          end
         OP_M5:   begin mul_a = MULW'(m3_ff);  mul_b = MULW'(m2_ff);           end
         OP_M7:   begin mul_a = MULW'(m5_ff);  mul_b = MULW'(m2_ff);           end
         OP_K_ACC: begin mul_a = MULW'(dvd_ff); mul_b = MULW'(k_recip(cmd.k)); end
         OP_DEG:  begin mul_a = MULW'(r30_ff); mul_b = MULW'(DEG_PER_RAD_Q24); end
         default: begin mul_a = '0;            mul_b = '0;                     end
      endcase
      prod     = PW'(mul_a) * PW'(mul_b);
      prod_rnd = prod + (PW'(1) << 29);
      q30      = prod_rnd[30 +: Q30_W];
      deg_rnd  = (prod + (PW'(1) << (53 - FRAC_BITS))) >> (54 - FRAC_BITS);
   end

   always_comb begin
      num     = NW'(s_p) + NW'(s_q) - NW'(s_opp);
      num_abs = num[NW-1] ? NW'(-num) : NW'(num);
      div_r2  = {rem_ff, dvd_ff[DVD_W-1]};
      div_ge  = div_r2 >= (DW+1)'(den_ff);
      sq_r2   = {srem_ff, sv_ff[VW-1 -: 2]};
      sq_trial = (RW+4)'({root_ff, 2'b01});
      sq_ge   = sq_r2 >= sq_trial;
      rad_rnd = (r30_ff + (SUM_W'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      rad_val = err_ff ? RAD_W'(-(RAD_W'(1) << FRAC_BITS)) : RAD_W'(rad_rnd);
      deg_val = err_ff ? DEG_W'(-deg_rnd) : DEG_W'(deg_rnd);
   end

   always_comb begin
      pt_in = pt_ff;
      acc_in = acc_ff;
      sa_in = sa_ff; sb_in = sb_ff; sc_in = sc_ff;
      la_in = la_ff; lb_in = lb_ff; lc_in = lc_ff;
      sv_in = sv_ff; root_in = root_ff; srem_in = srem_ff;
      den_in = den_ff; mag_in = mag_ff; rem_in = rem_ff;
      neg_in = neg_ff; err_in = err_ff;
      dvd_in = dvd_ff; quo_in = quo_ff;
      c30_in = c30_ff; m2_in = m2_ff; m3_in = m3_ff; m5_in = m5_ff; m7_in = m7_ff;
      sum_in = sum_ff; r30_in = r30_ff;
      rad_in = rad_ff; deg_in = deg_ff; errs_in = errs_ff;
      out_in = out_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            for (int i = 0; i < 6; i++) begin
               pt_in[i] = coords[i*CW +: CW];
            end
         end
         OP_SQX: acc_in = SQW'(prod);
         OP_SQY: begin
            unique case (cmd.idx)
               2'd0:    sa_in = acc_ff + SQW'(prod);
               2'd1:    sb_in = acc_ff + SQW'(prod);
               default: sc_in = acc_ff + SQW'(prod);
            endcase
         end
         OP_SQRT_INIT: begin
            sv_in   = VW'(s_sel) << 16;
            root_in = '0;
            srem_in = '0;
         end
         OP_SQRT_STEP: begin
            srem_in = sq_ge ? (RW+2)'(sq_r2 - sq_trial) : (RW+2)'(sq_r2);
            root_in = {root_ff[RW-2:0], sq_ge};
            sv_in   = sv_ff << 2;
         end
         OP_SQRT_DONE: begin
            unique case (cmd.idx)
               2'd0:    la_in = l_sel;
               2'd1:    lb_in = l_sel;
               default: lc_in = l_sel;
            endcase
         end
         OP_DEN: begin
            den_in = DW'({prod, 1'b0});
            mag_in = DW'(num_abs) << 16;
            neg_in = num[NW-1];
            err_in = 1'b0;
         end
         OP_CHECK: err_in = (den_ff == '0) || ((DW+1)'(mag_ff) >= {den_ff, 1'b0});
         OP_COS_INIT: begin
            rem_in = mag_ff >> 1;
            dvd_in = {mag_ff[0], {(DVD_W-1){1'b0}}};
            quo_in = '0;
         end
         OP_DIV_STEP: begin
            rem_in = div_ge ? DW'(div_r2 - (DW+1)'(den_ff)) : DW'(div_r2);
            dvd_in = dvd_ff << 1;
            quo_in = {quo_ff[DVD_W-2:0], div_ge};
         end
         OP_COS_DONE: begin
            c30_in = quo_ff[Q30_W-1:0];
            sum_in = SUM_W'(quo_ff);
            err_in = quo_ff > DVD_W'(ONE_Q30);
         end
         OP_M2: m2_in = q30;
         OP_M3: m3_in = q30;
         OP_M5: m5_in = q30;
         OP_M7: m7_in = q30;
         OP_K_INIT: begin
            unique case (cmd.k)
               K_CUBE:  dvd_in = DVD_W'(m3_ff);
               K_FIFTH: dvd_in = (DVD_W'(m5_ff) + (DVD_W'(m5_ff) << 1)) >> 3;
               default: dvd_in = (DVD_W'(m7_ff) + (DVD_W'(m7_ff) << 2)) >> 4;
            endcase
         end
         OP_K_ACC: sum_in = sum_ff + SUM_W'(prod >> K_RECIP_SHIFT);
         OP_FIN: begin
            if (err_ff) begin
               r30_in = ONE_Q30;
            end else if (neg_ff) begin
               r30_in = HALF_PI_Q30 + sum_ff;
            end else begin
               r30_in = HALF_PI_Q30 - sum_ff;
            end
         end
         OP_DEG: begin
            rad_in[cmd.idx]  = rad_val;
            deg_in[cmd.idx]  = deg_val;
            errs_in[cmd.idx] = err_ff;
         end
         OP_EMIT: begin
            out_in = OUT_W'({errs_ff, deg_ff[2], rad_ff[2], deg_ff[1], rad_ff[1],
                             deg_ff[0], rad_ff[0]});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
      acc_ff <= acc_in;
      sa_ff <= sa_in; sb_ff <= sb_in; sc_ff <= sc_in;
      la_ff <= la_in; lb_ff <= lb_in; lc_ff <= lc_in;
      sv_ff <= sv_in; root_ff <= root_in; srem_ff <= srem_in;
      den_ff <= den_in; mag_ff <= mag_in; rem_ff <= rem_in;
      neg_ff <= neg_in; err_ff <= err_in;
      dvd_ff <= dvd_in; quo_ff <= quo_in;
      c30_ff <= c30_in; m2_ff <= m2_in; m3_ff <= m3_in; m5_ff <= m5_in; m7_ff <= m7_in;
      sum_ff <= sum_in; r30_ff <= r30_in;
      rad_ff <= rad_in; deg_ff <= deg_in; errs_ff <= errs_in;
      out_ff <= out_in;
   end

   assign stat.err = err_ff;
   assign result   = out_ff;

endmodule
`default_nettype wire

// ----- hdl/tafp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tafp_ctrl
// Sequencer: walks sides, roots, the three angles and the output transfer.
// -----------------------------------------------------------------------------
module tafp_ctrl
   import tafp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam int RW   = COORD_WIDTH + 9;
   localparam int MAXC = (RW > COS_STEPS) ? RW : COS_STEPS;
   localparam int CNTW = $clog2(MAXC);

   typedef enum logic [19:0] {
      S_IDLE      = 20'h00001,
      S_SQX       = 20'h00002,
      S_SQY       = 20'h00004,
      S_SQRT_INIT = 20'h00008,
      S_SQRT_STEP = 20'h00010,
      S_SQRT_DONE = 20'h00020,
      S_DEN       = 20'h00040,
      S_CHECK     = 20'h00080,
      S_COS_INIT  = 20'h00100,
      S_COS_STEP  = 20'h00200,
      S_COS_DONE  = 20'h00400,
      S_M2        = 20'h00800,
      S_M3        = 20'h01000,
      S_M5        = 20'h02000,
      S_M7        = 20'h04000,
      S_K_INIT    = 20'h08000,
      S_K_ACC     = 20'h10000,
      S_FIN       = 20'h20000,
      S_DEG       = 20'h40000,
      S_EMIT      = 20'h80000
   } state_type;

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [1:0]      idx_ff, idx_in, k_ff, k_in;
   logic            vld_ff, vld_in;
   logic            emit_ok;

   assign emit_ok = !vld_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      vld_in   = vld_ff && !rsp_tready;
      cmd.op   = OP_NONE;
      cmd.idx  = idx_ff;
      cmd.k    = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               idx_in   = 2'd0;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op = OP_SQY;
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = S_SQRT_INIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_SQX;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = S_SQRT_STEP;
         end
         S_SQRT_STEP: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(RW - 1)) begin
               state_in = S_SQRT_DONE;
            end
         end
         S_SQRT_DONE: begin
            cmd.op = OP_SQRT_DONE;
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = S_DEN;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_SQRT_INIT;
            end
         end
         S_DEN: begin
            cmd.op   = OP_DEN;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = S_COS_INIT;
         end
         S_COS_INIT: begin
            if (stat.err) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_COS_INIT;
               cnt_in   = '0;
               state_in = S_COS_STEP;
            end
         end
         S_COS_STEP: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(COS_STEPS - 1)) begin
               state_in = S_COS_DONE;
            end
         end
         S_COS_DONE: begin
            cmd.op   = OP_COS_DONE;
            state_in = S_M2;
         end
         S_M2: begin
            if (stat.err) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_M2;
               state_in = S_M3;
            end
         end
         S_M3: begin
            cmd.op   = OP_M3;
            state_in = S_M5;
         end
         S_M5: begin
            cmd.op   = OP_M5;
            state_in = S_M7;
         end
         S_M7: begin
            cmd.op   = OP_M7;
            k_in     = K_CUBE;
            state_in = S_K_INIT;
         end
         S_K_INIT: begin
            cmd.op   = OP_K_INIT;
            state_in = S_K_ACC;
         end
         S_K_ACC: begin
            cmd.op = OP_K_ACC;
            if (k_ff == K_SEVENTH) begin
               state_in = S_FIN;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_K_INIT;
            end
         end
         S_FIN: begin
            cmd.op   = OP_FIN;
            state_in = S_DEG;
         end
         S_DEG: begin
            cmd.op = OP_DEG;
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = S_EMIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_DEN;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               cmd.op   = OP_EMIT;
               vld_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         cnt_ff   <= '0;
         idx_ff   <= 2'd0;
         k_ff     <= K_CUBE;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         k_ff     <= k_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SQX))
      else $error("accepted transfer did not start the side pass");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && vld_ff && !rsp_tready) |=> (state_ff == S_EMIT))
      else $error("result overwritten while output stalled");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && emit_ok) |=> vld_ff)
      else $error("emit did not raise rsp_tvalid");

   a_k_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_K_ACC) |-> (k_ff == K_CUBE || k_ff == K_FIFTH || k_ff == K_SEVENTH))
      else $error("series term index out of range");

endmodule
`default_nettype wire

// ----- hdl/triangle_angles_from_points.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// triangle_angles_from_points
// Three inner angles of a triangle from its corners, law of cosines.
// -----------------------------------------------------------------------------
// One triangle at a time: a transfer is taken only while the sequencer is idle,
// and each one goes through accepting it, the squared sides, the bit-pair
// square roots, the three angles (each mostly the shared one-bit-per-cycle
// divider doing the cosine), and loading the output register. An angle whose
// side is zero or whose cosine is out of range finishes early with its error
// bit set. The result sits in an output register, so the next triangle is
// taken while it waits.
module triangle_angles_from_points
   import tafp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // first_x, first_y, second_x, second_y, third_x, third_y
   input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // angle_one_rad, angle_one_deg, angle_two_rad, angle_two_deg,
   // angle_three_rad, angle_three_deg, error_one, error_two, error_three
   output logic [OUT_W-1:0]          rsp_tdata
);

   cmd_type  cmd;
   stat_type stat;

   tafp_ctrl #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tafp_dp #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock  (clock),
      .cmd    (cmd),
      .coords (req_tdata[6*COORD_WIDTH-1:0]),
      .stat   (stat),
      .result (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- tb/tb_triangle_angles_from_points.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_triangle_angles_from_points
// Self-checking bench for the triangle angle block.
// Random and corner-case triangles go in on the request stream. A scoreboard
// predicts the angles and error bits of each one, and every response transfer
// is checked in order against that prediction. The sender and the receiver
// idle at random in several phases.
// -----------------------------------------------------------------------------

class angle_scoreboard;
   localparam int RW = tafp_pkg::RAD_W;
   localparam int DW = tafp_pkg::DEG_W;
   localparam longint HALF_PI = 64'd1686629713;
   localparam longint ONE30   = 64'd1 << 30;
   localparam longint DPR     = 64'd961263669;

   logic [tafp_pkg::OUT_W-1:0] pending_angles[$];
   int errors;
   int shown;

   function new();
      errors = 0;
      shown  = 0;
   endfunction

   function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int s = 31; s >= 0; s--) begin
         t = r | (64'd1 << s);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function longint unsigned sqd(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = bx - ax;
      dy = by - ay;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx * dx + dy * dy;
   endfunction

   function longint unsigned qmul(longint unsigned p, longint unsigned q);
      return (p * q + (64'd1 << 29)) >> 30;
   endfunction

   function longint unsigned to_deg(longint unsigned r30);
      return (r30 * DPR + (64'd1 << 37)) >> 38;
   endfunction

   // err bit returned; rad/deg filled
   function bit angle(longint unsigned so, longint unsigned sp, longint unsigned sq,
                      longint unsigned lp, longint unsigned lq,
                      output logic [RW-1:0] rad, output logic [DW-1:0] deg);
      longint unsigned den, mag, ip, rem, frac, c, m2, m3, m5, m7, sum;
      longint num, r30;
      bit neg;
      den  = 2 * lp * lq;
      num  = longint'(sp + sq) - longint'(so);
      neg  = num < 0;
      frac = 0;
      if (den != 0) begin
         mag = longint'(neg ? -num : num) << 16;
         ip  = mag / den;
         rem = mag % den;
         if (ip < 2) begin
            for (int i = 0; i < 30; i++) begin
               rem  = rem << 1;
               frac = frac << 1;
               if (rem >= den) begin
                  rem  = rem - den;
                  frac = frac | 1;
               end
            end
            c = (ip << 30) | frac;
            if (c <= ONE30) begin
               m2  = qmul(c, c);
               m3  = qmul(m2, c);
               m5  = qmul(m3, m2);
               m7  = qmul(m5, m2);
               sum = c + m3 / 6 + (3 * m5) / 40 + (5 * m7) / 112;
               r30 = neg ? HALF_PI + longint'(sum) : HALF_PI - longint'(sum);
               rad = RW'((longint'(r30) + (64'd1 << 13)) >> 14);
               deg = DW'(to_deg(r30));
               return 1'b0;
            end
         end
      end
      rad = RW'(-(64'sd1 << 16));
      deg = DW'(-longint'(to_deg(ONE30)));
      return 1'b1;
   endfunction

   function void note_triangle(logic [95:0] d);
      longint x1, y1, x2, y2, x3, y3;
      longint unsigned sa, sb, sc, la, lb, lc;
      logic [RW-1:0] r1, r2, r3;
      logic [DW-1:0] d1, d2, d3;
      bit e1, e2, e3;
      x1 = longint'($signed(d[15:0]));
      y1 = longint'($signed(d[31:16]));
      x2 = longint'($signed(d[47:32]));
      y2 = longint'($signed(d[63:48]));
      x3 = longint'($signed(d[79:64]));
      y3 = longint'($signed(d[95:80]));
      sa = sqd(x1, y1, x2, y2);
      sb = sqd(x2, y2, x3, y3);
      sc = sqd(x1, y1, x3, y3);
      la = isqrt(sa << 16);
      lb = isqrt(sb << 16);
      lc = isqrt(sc << 16);
      e1 = angle(sa, sb, sc, lb, lc, r1, d1);
      e2 = angle(sb, sa, sc, la, lc, r2, d2);
      e3 = angle(sc, sa, sb, la, lb, r3, d3);
      pending_angles.push_back(tafp_pkg::OUT_W'({e3, e2, e1, d3, r3, d2, r2, d1, r1}));
   endfunction

   function void check_angles(logic [tafp_pkg::OUT_W-1:0] got);
      logic [tafp_pkg::OUT_W-1:0] exp;
      if (pending_angles.size() == 0) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("unexpected response %h", got);
         end
         return;
      end
      exp = pending_angles.pop_front();
      if (got !== exp) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("mismatch: expected %h actual %h", exp, got);
         end
      end
   endfunction
endclass

module tb_triangle_angles_from_points;
   import tafp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;

   angle_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   int hold_cycles = 0;

   triangle_angles_from_points dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_angles(rsp_tdata);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_triangle(logic [95:0] d);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_triangle(d);
   endtask

   task automatic send_pts(int x1, int y1, int x2, int y2, int x3, int y3);
      send_triangle({16'(y3), 16'(x3), 16'(y2), 16'(x2), 16'(y1), 16'(x1)});
   endtask

   function automatic logic [15:0] rnd_coord(int span);
      return 16'($urandom_range(2 * span) - span);
   endfunction

   task automatic send_random();
      int span;
      case ($urandom_range(3))
         0: span = 32767;
         1: span = 2000;
         2: span = 64;
         default: span = 4;
      endcase
      if ($urandom_range(9) == 0)
         send_triangle({$urandom(), $urandom(), $urandom()});
      else if ($urandom_range(9) == 0) begin
         logic [15:0] x, y;
         x = rnd_coord(span);
         y = rnd_coord(span);
         send_triangle({rnd_coord(span), rnd_coord(span), y, x, y, x});
      end else
         send_triangle({rnd_coord(span), rnd_coord(span), rnd_coord(span),
                        rnd_coord(span), rnd_coord(span), rnd_coord(span)});
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_angles.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pts(0, 0, 0, 0, 0, 0);
      send_pts(0, 0, 16, 0, 0, 16);
      send_pts(0, 0, 16, 0, 8, 14);
      send_pts(0, 0, 16, 0, 32, 0);
      send_pts(0, 0, 16, 0, 8, 0);
      send_pts(-32768, -32768, 32767, 32767, -32768, 32767);
      send_pts(32767, -32768, -32768, 32767, 32767, 32767);
      send_pts(-32768, -32768, 32767, -32768, 0, 32767);
      send_pts(5, 5, 5, 5, 100, -7);
      send_pts(0, 0, 1, 0, 0, 1);
      send_pts(0, 0, 1000, 1, -1000, 0);
      send_pts(-1, -1, -1, -1, -1, -1);
      send_pts(32767, 32767, -32768, -32768, 0, 0);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 82 : 10) : 0;
         recv_stall = (ph == 2) ? 82 : ((ph == 3) ? 10 : 0);
         if (ph == 0) hold_cycles = 3000;
         for (int i = 0; i < 200; i++) send_random();
         drain();
      end
      send_idle = 0;
      recv_stall = 0;
      repeat (1200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_angles.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule

// ----- filelist.f -----
hdl/tafp_pkg.sv
hdl/tafp_dp.sv
hdl/tafp_ctrl.sv
hdl/triangle_angles_from_points.sv
tb/tb_triangle_angles_from_points.sv
